### hw/rtl/crc16e_pkg.sv
// ----------------------------------------------------------------------------
// crc16e_pkg
// Shared types, register indexes and bit-level helpers for the CRC-16 engine.
// ----------------------------------------------------------------------------
package crc16e_pkg;

	localparam int unsigned CrcWidth  = 16;
	localparam int unsigned ByteWidth = 8;
	localparam int unsigned CfgIdxW   = 2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_POLY    = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_INIT    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_XOROUT  = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_REFLECT = 2'd3;

	// Register values after reset.
	localparam logic [CrcWidth-1:0] POLY_RST    = 16'hA001;
	localparam logic [CrcWidth-1:0] INIT_RST    = 16'h0000;
	localparam logic [CrcWidth-1:0] XOROUT_RST  = 16'h0000;
	localparam logic                REFLECT_RST = 1'b1;

	typedef struct packed {
		logic [CrcWidth-1:0] poly;
		logic [CrcWidth-1:0] init;
		logic [CrcWidth-1:0] xorout;
		logic                reflect;
	} crc_cfg_t;

	function automatic logic [ByteWidth-1:0] flip8(input logic [ByteWidth-1:0] v);
		logic [ByteWidth-1:0] r;
		for (int i = 0; i < ByteWidth; i++) begin
			r[i] = v[ByteWidth-1-i];
		end
		return r;
	endfunction

	function automatic logic [CrcWidth-1:0] flip16(input logic [CrcWidth-1:0] v);
		logic [CrcWidth-1:0] r;
		for (int i = 0; i < CrcWidth; i++) begin
			r[i] = v[CrcWidth-1-i];
		end
		return r;
	endfunction

	// One reflected byte update: XOR the byte into the low bits, then eight
	// right shifts, each folding in the polynomial when a one drops out.
	function automatic logic [CrcWidth-1:0] crc_byte(
		input logic [CrcWidth-1:0]  rem,
		input logic [ByteWidth-1:0] b,
		input logic [CrcWidth-1:0]  poly
	);
		logic [CrcWidth-1:0] r;
		r = rem ^ {{(CrcWidth-ByteWidth){1'b0}}, b};
		for (int i = 0; i < ByteWidth; i++) begin
			if (r[0]) begin
				r = (r >> 1) ^ poly;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/configurable_crc16_engine.sv
// ----------------------------------------------------------------------------
// configurable_crc16_engine
// Configurable CRC-16 engine, one message byte per clock while in_stall is low.
// ----------------------------------------------------------------------------
// Usage:
// Message bytes arrive on the input channel (in_valid / in_stall) with
// first_byte marking the opening word of a message and last_byte its final
// word. Every accepted word updates the running remainder; only a word with
// last_byte set produces a result word, crc_value, on the output channel
// (out_valid / out_stall).
// An accepted word is held in the input register and runs through the byte
// update as it leaves; a final word also loads the result register.
// Throughput is one word per clock while in_stall is low; the bound is the
// single 8-step reflected byte update that feeds the remainder register.
// When the receiver stalls with a result waiting, the input register keeps
// absorbing words that carry no result; a second result word waits in the
// input register and in_stall rises until the output slot frees.
// Configuration writes (cfg_valid / cfg_ready) are always taken and should be
// issued only while the engine is idle. cfg_index selects the polynomial,
// start value, output mask or reflection control.
// Reset clears the remainder to zero, empties both registers and loads the
// default settings: reflected polynomial 0xA001, start 0, mask 0, reflected.
// ----------------------------------------------------------------------------
module configurable_crc16_engine
	import crc16e_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ByteWidth-1:0] data_byte,
	input  logic                 first_byte,
	input  logic                 last_byte,
	// Output channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CrcWidth-1:0]  crc_value,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CrcWidth-1:0]  cfg_data
);

	crc_cfg_t             cfg_q;

	logic                 valid_s1;
	logic [ByteWidth-1:0] byte_s1;
	logic                 first_s1;
	logic                 last_s1;

	logic                 out_valid_q;
	logic [CrcWidth-1:0]  crc_q;

	logic                 out_free;
	logic                 advance;
	logic                 in_take;
	logic [CrcWidth-1:0]  crc_fin;

	// The output slot is free when empty or being drained this cycle. A word
	// without a result can always leave the input register; a final word
	// needs the output slot.
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && (!last_s1 || out_free);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign crc_value = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly    <= POLY_RST;
			cfg_q.init    <= INIT_RST;
			cfg_q.xorout  <= XOROUT_RST;
			cfg_q.reflect <= REFLECT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_POLY:    cfg_q.poly    <= cfg_data;
				CFG_INIT:    cfg_q.init    <= cfg_data;
				CFG_XOROUT:  cfg_q.xorout  <= cfg_data;
				CFG_REFLECT: cfg_q.reflect <= cfg_data[0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	crc16e_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.advance  (advance),
		.byte_s1  (byte_s1),
		.first_s1 (first_s1),
		.crc_fin  (crc_fin)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			crc_q <= crc_fin;
		end
	end

endmodule

### hw/rtl/crc16e_core.sv
// ----------------------------------------------------------------------------
// crc16e_core
// Running remainder register and the combinational byte update around it.
// ----------------------------------------------------------------------------
module crc16e_core
	import crc16e_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  crc_cfg_t             cfg,
	input  logic                 advance,
	input  logic [ByteWidth-1:0] byte_s1,
	input  logic                 first_s1,
	output logic [CrcWidth-1:0]  crc_fin
);

	logic [CrcWidth-1:0]  remainder_q;
	logic [CrcWidth-1:0]  start_rem;
	logic [CrcWidth-1:0]  rem_next;
	logic [ByteWidth-1:0] byte_in;

	// The start value and the byte are bit-reversed when reflection is off.
	always_comb begin
		if (first_s1) begin
			start_rem = cfg.reflect ? cfg.init : flip16(cfg.init);
		end else begin
			start_rem = remainder_q;
		end
		byte_in  = cfg.reflect ? byte_s1 : flip8(byte_s1);
		rem_next = crc_byte(start_rem, byte_in, cfg.poly);
		crc_fin  = (cfg.reflect ? rem_next : flip16(rem_next)) ^ cfg.xorout;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= '0;
		end else if (advance) begin
			remainder_q <= rem_next;
		end
	end

endmodule

### sim/configurable_crc16_engine_tb.sv
// ----------------------------------------------------------------------------
// configurable_crc16_engine_tb
// Self-checking testbench for the configurable CRC-16 engine.
// ----------------------------------------------------------------------------
// Message bytes go in one word per handshake. The testbench watches every
// accepted word and carries its own running remainder and copy of the four
// settings. Each word with last_byte set queues the CRC it should produce.
// Every result word that the engine delivers is checked against the oldest
// queued CRC. The run covers these parts in order:
// - directed messages, including bytes with no opening flag;
// - well-known CRC presets, the all-zero and all-one settings, and a register
//   change in the middle of a message;
// - random traffic under four idle and stall patterns;
// - a long receiver hold-off that fills the engine and stalls its input.
// ----------------------------------------------------------------------------
module configurable_crc16_engine_tb
	import crc16e_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles the engine may still spend on words that carry no result.
	localparam int SettleCycles  = 4;
	// Receiver hold-off used to back the engine up.
	localparam int LongHold      = 300;
	// Cycles with no handshake on any channel before the run is abandoned.
	localparam int WatchdogLimit = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ByteWidth-1:0] data_byte = '0;
	logic                 first_byte = 1'b0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CrcWidth-1:0]  crc_value;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index = '0;
	logic [CrcWidth-1:0]  cfg_data = '0;

	// Settings and running remainder as the engine should hold them.
	crc_cfg_t             model_cfg;
	logic [CrcWidth-1:0]  model_rem;
	// CRC values still owed by the engine, oldest first.
	logic [CrcWidth-1:0]  owed_crcs[$];

	int unsigned          fail_count = 0;
	int unsigned          quiet_cycles = 0;
	int                   send_idle_pct = 0;
	int                   stall_pct = 0;
	logic                 hold_request = 1'b0;

	configurable_crc16_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.crc_value  (crc_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bit order reversal of a byte, built by shifting bits out of one end
	// and into the other.
	function automatic logic [ByteWidth-1:0] mirror8(input logic [ByteWidth-1:0] v);
		logic [ByteWidth-1:0] acc;
		acc = '0;
		repeat (ByteWidth) begin
			acc = {acc[ByteWidth-2:0], v[0]};
			v = v >> 1;
		end
		return acc;
	endfunction

	// A 16-bit reversal is the two mirrored bytes with their places swapped.
	function automatic logic [CrcWidth-1:0] mirror16(input logic [CrcWidth-1:0] v);
		return {mirror8(v[7:0]), mirror8(v[15:8])};
	endfunction

	// Right-shifting CRC step: the byte enters the low end of the remainder,
	// and each of the eight shifts folds in the polynomial when a one falls out.
	function automatic logic [CrcWidth-1:0] crc_fold_byte(
		input logic [CrcWidth-1:0]  rem,
		input logic [ByteWidth-1:0] b,
		input logic [CrcWidth-1:0]  poly
	);
		logic [CrcWidth-1:0] acc;
		acc = rem ^ CrcWidth'(b);
		repeat (ByteWidth) begin
			acc = acc[0] ? ((acc >> 1) ^ poly) : (acc >> 1);
		end
		return acc;
	endfunction

	// Sometimes an extreme value, otherwise any 16-bit value.
	function automatic logic [CrcWidth-1:0] pick_reg_value();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return CrcWidth'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// All three channels are sampled here at the clock edge. Inputs are
	// driven with nonblocking assignments, so the values seen here are the
	// ones that were present for the handshake. A settings write changes the
	// model, a finished result word is checked, and an accepted input word
	// moves the model's remainder on. The same block also runs the watchdog.
	always @(posedge clk or negedge arst_n) begin : monitor
		logic [CrcWidth-1:0]  want;
		logic [ByteWidth-1:0] fed;
		logic                 busy;
		if (!arst_n) begin
			model_cfg.poly    = POLY_RST;
			model_cfg.init    = INIT_RST;
			model_cfg.xorout  = XOROUT_RST;
			model_cfg.reflect = REFLECT_RST;
			model_rem         = '0;
			quiet_cycles      = 0;
		end else begin
			busy = 1'b0;
			if (cfg_valid && cfg_ready) begin
				busy = 1'b1;
				case (cfg_index)
					CFG_POLY:    model_cfg.poly = cfg_data;
					CFG_INIT:    model_cfg.init = cfg_data;
					CFG_XOROUT:  model_cfg.xorout = cfg_data;
					CFG_REFLECT: model_cfg.reflect = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				busy = 1'b1;
				if (owed_crcs.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %h",
						$time, crc_value);
					fail_count++;
				end else begin
					want = owed_crcs.pop_front();
					if (crc_value !== want) begin
						$display("%0t: crc_value mismatch, expected %h, actual %h",
							$time, want, crc_value);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				busy = 1'b1;
				// The start value is stored in reflected form, so it is
				// mirrored on load when the engine works MSB-first.
				if (first_byte) begin
					model_rem = model_cfg.reflect ? model_cfg.init : mirror16(model_cfg.init);
				end
				fed = model_cfg.reflect ? data_byte : mirror8(data_byte);
				model_rem = crc_fold_byte(model_rem, fed, model_cfg.poly);
				if (last_byte) begin
					owed_crcs.push_back((model_cfg.reflect ? model_rem : mirror16(model_rem))
						^ model_cfg.xorout);
				end
			end
			quiet_cycles = busy ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls at the current rate. On request it instead
	// holds the output stalled for a long stretch that it counts itself.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offers one word and returns at the edge that accepts it. The valid
	// signal is left high, so back-to-back words keep it raised without a
	// gap. It is lowered only for a random idle cycle or by wait_idle.
	task automatic send_word(
		input logic [ByteWidth-1:0] value,
		input logic                 is_first,
		input logic                 is_last
	);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= value;
		first_byte <= is_first;
		last_byte  <= is_last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_word(ByteWidth'($urandom_range(255)), i == 0, i == len - 1);
		end
	endtask

	// Stops sending and waits until every owed result has arrived. The queue
	// is polled on the falling edge, after the monitor has handled the rising
	// one. The settle cycles then let any word with no result finish its
	// update.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (owed_crcs.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Back-to-back register writes keep cfg_valid high. The caller lowers it
	// when the last write is done.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CrcWidth-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_settings(
		input logic [CrcWidth-1:0] poly,
		input logic [CrcWidth-1:0] init,
		input logic [CrcWidth-1:0] xorout,
		input logic                reflect
	);
		write_reg(CFG_POLY, poly);
		write_reg(CFG_INIT, init);
		write_reg(CFG_XOROUT, xorout);
		write_reg(CFG_REFLECT, CrcWidth'(reflect));
		cfg_valid <= 1'b0;
	endtask

	// Reset settings. The first bytes carry no opening flag and so continue
	// from the cleared remainder. The next bytes follow a finished message
	// without a new opening flag. Single-byte messages then use the extreme
	// byte values, and a short message uses all three flag combinations.
	task automatic test_directed_messages();
		send_word(8'h5A, 1'b0, 1'b0);
		send_word(8'hA5, 1'b0, 1'b1);
		send_word(8'h01, 1'b0, 1'b0);
		send_word(8'h80, 1'b0, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'hFF, 1'b1, 1'b1);
		send_word(8'h31, 1'b1, 1'b0);
		send_word(8'h32, 1'b0, 1'b0);
		send_word(8'h33, 1'b0, 1'b1);
		wait_idle();
	endtask

	// Known presets on the standard check string or its first four bytes, the
	// all-zero and all-one extremes, and settings rewritten while a message is open.
	task automatic test_register_settings();
		byte unsigned check_str[9];
		check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

		// Reflected preset with both masks set.
		apply_settings(16'h8408, 16'hFFFF, 16'hFFFF, 1'b1);
		foreach (check_str[i]) send_word(check_str[i], i == 0, i == 8);
		wait_idle();

		// MSB-first preset: bytes, start value and result are mirrored.
		apply_settings(16'h8408, 16'hFFFF, 16'h0000, 1'b0);
		for (int i = 0; i < 4; i++) send_word(check_str[i], i == 0, i == 3);
		wait_idle();

		apply_settings(16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'hA5, 1'b0, 1'b1);
		wait_idle();

		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'h5A, 1'b0, 1'b1);
		wait_idle();

		// Open a message, then pause and change the polynomial and the
		// reflection. The start value is changed too, but that matters only
		// at the next opening flag.
		apply_settings(POLY_RST, INIT_RST, XOROUT_RST, REFLECT_RST);
		send_word(8'h31, 1'b1, 1'b0);
		send_word(8'h32, 1'b0, 1'b0);
		wait_idle();
		write_reg(CFG_POLY, 16'hC002);
		write_reg(CFG_REFLECT, CrcWidth'(1'b0));
		write_reg(CFG_INIT, 16'h1234);
		cfg_valid <= 1'b0;
		send_word(8'h33, 1'b0, 1'b0);
		send_word(8'h34, 1'b0, 1'b1);
		wait_idle();
	endtask

	// Random traffic. Most of it is well-formed messages of random bytes,
	// mostly short, now and then long. About one pick in ten is a single noise word
	// with random flags. The settings are redrawn halfway through.
	task automatic test_random_traffic(input int idle_pct, input int stall_rate, input int n_words);
		int sent;
		int len;
		for (int half = 0; half < 2; half++) begin
			wait_idle();
			apply_settings(pick_reg_value(), pick_reg_value(), pick_reg_value(),
				1'($urandom_range(1)));
			send_idle_pct = idle_pct;
			stall_pct     = stall_rate;
			sent = 0;
			while (sent < n_words / 2) begin
				if ($urandom_range(9) == 0) begin
					send_word(ByteWidth'($urandom_range(255)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
					sent++;
				end else begin
					len = ($urandom_range(7) == 0) ? $urandom_range(32, 1) : $urandom_range(6, 1);
					send_message(len);
					sent += len;
				end
			end
		end
		wait_idle();
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	// The receiver holds off while the sender keeps offering short messages
	// with no gaps. The result slot and the input register fill up, and
	// in_stall must hold the sender back. Then the sender pauses until every
	// owed result is in.
	task automatic test_backpressure();
		int sent;
		wait_idle();
		apply_settings(16'h8408, 16'hFFFF, 16'hFFFF, 1'b1);
		hold_request = 1'b1;
		sent = 0;
		while (sent < 60) begin
			if ($urandom_range(1) == 0) begin
				send_message(1);
				sent++;
			end else begin
				send_message(2);
				sent += 2;
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_messages();
		test_register_settings();
		test_random_traffic(0, 0, 180);
		test_random_traffic(81, 0, 180);
		test_random_traffic(0, 81, 180);
		test_random_traffic(23, 23, 180);
		test_backpressure();

		// wait_idle has drained the queue and waited out the settle cycles.
		// Any stray result word in that time was counted by the monitor.
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
